FILE: hdl/keyboard_matrix_translator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the keyboard matrix translator RTL.
// Both expect signals named clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MATRIX_TRANSLATOR_TOP_MACROS_SVH
`define KEYBOARD_MATRIX_TRANSLATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define KMT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/kmt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_pkg
// Types, constants and helper functions of the keyboard matrix translator.
// ----------------------------------------------------------------------------
package kmt_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int SCAN_CODES    = 512;
    localparam int COLUMNS       = 8;

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 7;
    localparam int CODE_W     = 9;
    localparam int MASK_W     = 8;
    localparam int COL_W      = 3;
    localparam int SEL_W      = 8;
    localparam int POT_W      = 6;
    localparam int BTN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 16;

    localparam int TBL_AW     = $clog2(TABLE_ENTRIES);
    localparam int KEY_AW     = $clog2(SCAN_CODES);
    localparam int KROW_SHIFT = 3;
    localparam int KROW_BITS  = 1 << KROW_SHIFT;
    localparam int KROWS      = SCAN_CODES / KROW_BITS;
    localparam int KROW_AW    = $clog2(KROWS);

    localparam logic [CODE_W-1:0] SHIFT_RESET  = 9'd304;
    localparam logic [CODE_W-1:0] RSHIFT_RESET = 9'd303;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RSHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_EN = 2'd2;

    localparam logic [MASK_W-1:0] READ_BASE  = 8'd127;
    localparam logic [MASK_W-1:0] POT_BIT    = 8'h80;
    localparam logic [MASK_W-1:0] LFIRE1_CLR = 8'hFD;
    localparam logic [MASK_W-1:0] RFIRE1_CLR = 8'hFE;
    localparam logic [MASK_W-1:0] LFIRE2_CLR = 8'hF7;
    localparam logic [MASK_W-1:0] RFIRE2_CLR = 8'hFB;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_PRESS   = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic [POT_W-1:0]  dac_level;
        logic [POT_W-1:0]  pot_value;
        logic [SEL_W-1:0]  column_select;
        logic [COL_W-1:0]  col_second;
        logic [MASK_W-1:0] row_second;
        logic [COL_W-1:0]  col_first;
        logic [MASK_W-1:0] row_first;
        logic [CODE_W-1:0] scan_second;
        logic [CODE_W-1:0] scan_first;
        logic [IDX_W-1:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] k1;
        logic [CODE_W-1:0] k2;
        logic [MASK_W-1:0] m1;
        logic [COL_W-1:0]  c1;
        logic [MASK_W-1:0] m2;
        logic [COL_W-1:0]  c2;
    } tbl_entry_t;

    typedef enum logic [2:0] {
        S_INIT_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_KEY_WR,
        S_CLEAR,
        S_WALK_INIT,
        S_WALK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic item_load;
        logic tbl_write;
        logic key_write;
        logic clear_run;
        logic walk_start;
        logic walk_run;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  shift_release;
        logic  clear_last;
        logic  walk_done;
    } dp_status_t;

    // Row of the key-down memory that holds a scan code.
    function automatic logic [KROW_AW-1:0] key_row(input logic [CODE_W-1:0] code);
        logic [CODE_W+KEY_AW-1:0] ext;
        ext = (CODE_W + KEY_AW)'(code);
        return ext[KEY_AW-1:KROW_SHIFT];
    endfunction

    function automatic logic key_in_range(input logic [CODE_W-1:0] code);
        return (32'(code) < SCAN_CODES);
    endfunction

endpackage

FILE: hdl/kmt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_ctrl
// Sequencer: dispatches each transaction and steps the datapath through the
// key map update, clearing pass, table walk and result hand-off.
// ----------------------------------------------------------------------------
`include "keyboard_matrix_translator_top_macros.svh"

module kmt_ctrl
    import kmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_free,
    input  dp_status_t status,
    output logic       in_ready,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_INIT_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.item_load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.kind)
                    KIND_LOAD:
                    begin
                        cmd.tbl_write = 1'b1;
                        state_next    = S_RESULT;
                    end
                    KIND_READ:
                    begin
                        state_next = S_RESULT;
                    end
                    KIND_PRESS, KIND_RELEASE:
                    begin
                        // Releasing shift wipes the whole map, so the single-bit
                        // update is skipped.
                        state_next = status.shift_release ? S_CLEAR : S_KEY_WR;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end
            S_KEY_WR:
            begin
                cmd.key_write = 1'b1;
                state_next    = S_WALK_INIT;
            end
            S_CLEAR:
            begin
                cmd.clear_run = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_WALK_INIT;
                end
            end
            S_WALK_INIT:
            begin
                cmd.walk_start = 1'b1;
                state_next     = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (status.walk_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `KMT_ASSERT_IMP(a_walk_excl, cmd.walk_run, !cmd.clear_run && !cmd.key_write && !cmd.tbl_write, "walk overlaps a memory write")
    `KMT_ASSERT_IMP(a_result_free, cmd.result_load, out_free, "result loaded into a full output stage")
    `KMT_ASSERT_NEXT(a_start_walk, cmd.walk_start, cmd.walk_run, "walk did not follow its start")
    `KMT_ASSERT_NEXT(a_keywr_walk, cmd.key_write, cmd.walk_start, "key map update not followed by a rebuild")

endmodule

FILE: hdl/kmt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmt_datapath
// Configuration registers, translation table, key-down map, pipelined table
// walk, column row masks and column read logic.
// ----------------------------------------------------------------------------
module kmt_datapath
    import kmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  kind_t                 in_kind,
    input  in_item_t              in_item,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    output logic [MASK_W-1:0]     read_data,
    output logic                  keyboard_irq
);

    logic [CODE_W-1:0] shift_reg;
    logic [CODE_W-1:0] rshift_reg;
    logic              irq_en_reg;

    kind_t    kind_reg;
    in_item_t item_reg;

    tbl_entry_t tbl_mem [TABLE_ENTRIES];
    logic       tbl_valid_reg [TABLE_ENTRIES];
    logic [KROW_BITS-1:0] key_mem [KROWS];

    logic [KROW_AW-1:0] clr_reg;
    logic [TBL_AW:0]    idx_reg;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               t_ok_reg;
    tbl_entry_t         t_data_reg;
    tbl_entry_t         s2_entry_reg;
    logic [KROW_BITS-1:0] km_a_reg;
    logic [KROW_BITS-1:0] km_b_reg;
    logic [MASK_W-1:0]    col_rows_reg [COLUMNS];
    logic [MASK_W-1:0]    col_rows_next [COLUMNS];

    logic [CODE_W-1:0]        ev_code;
    tbl_entry_t               new_entry;
    logic [IDX_W+TBL_AW-1:0]  slot_ext;
    logic [TBL_AW-1:0]        slot_addr;
    logic                     slot_ok;
    logic [TBL_AW-1:0]        rd_addr;
    logic                     issue;
    tbl_entry_t               s1_entry;
    logic [KROW_AW-1:0]       a_addr;
    logic                     down1;
    logic                     down2;
    logic                     single_key;
    logic                     pair_key;
    logic                     add_masks;
    logic                     end_hit;
    logic                     walk_done;
    logic                     km_we;
    logic [KROW_AW-1:0]       km_waddr;
    logic [KROW_BITS-1:0]     km_wdata;
    logic [KROW_BITS-1:0]     key_row_upd;
    logic [SEL_W-1:0]         sel;
    logic [MASK_W-1:0]        acc;
    logic [MASK_W-1:0]        rd_val;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= SHIFT_RESET;
            rshift_reg <= RSHIFT_RESET;
            irq_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SHIFT)
            begin
                shift_reg <= cfg_data;
            end
            else if (cfg_index == CFG_RSHIFT)
            begin
                rshift_reg <= cfg_data;
            end
            else if (cfg_index == CFG_IRQ_EN)
            begin
                irq_en_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_load)
        begin
            kind_reg <= in_kind;
            item_reg <= in_item;
        end
    end

    // Right shift folds onto shift in key events.
    assign ev_code = (item_reg.scan_first == rshift_reg) ? shift_reg : item_reg.scan_first;

    // Table entry as stored: shift moved to first, a lone second code moved up.
    always_comb
    begin
        new_entry    = '0;
        new_entry.k1 = item_reg.scan_first;
        new_entry.k2 = item_reg.scan_second;
        new_entry.m1 = item_reg.row_first;
        new_entry.c1 = item_reg.col_first;
        new_entry.m2 = item_reg.row_second;
        new_entry.c2 = item_reg.col_second;
        if (item_reg.scan_second == shift_reg)
        begin
            new_entry.k2 = item_reg.scan_first;
            new_entry.k1 = shift_reg;
        end
        if (new_entry.k1 == '0 && new_entry.k2 != '0)
        begin
            new_entry.k1 = new_entry.k2;
            new_entry.k2 = '0;
        end
    end

    assign slot_ext  = (IDX_W + TBL_AW)'(item_reg.entry_index);
    assign slot_addr = slot_ext[TBL_AW-1:0];
    assign slot_ok   = (32'(item_reg.entry_index) < TABLE_ENTRIES);

    // Translation table with a valid bit per slot; an unwritten slot reads as
    // an all-zero terminator.
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_write && slot_ok)
        begin
            tbl_mem[slot_addr] <= new_entry;
        end
        t_data_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                tbl_valid_reg[i] <= 1'b0;
            end
        end
        else if (cmd.tbl_write && slot_ok)
        begin
            tbl_valid_reg[slot_addr] <= 1'b1;
        end
    end

    // Walk pipeline: table read, key map read, evaluate.
    assign rd_addr = idx_reg[TBL_AW-1:0];
    assign issue   = cmd.walk_run && !walk_done && (32'(idx_reg) < TABLE_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            t_ok_reg     <= 1'b0;
        end
        else if (cmd.walk_start)
        begin
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg && cmd.walk_run && !walk_done;
            t_ok_reg     <= tbl_valid_reg[rd_addr];
            if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign s1_entry = t_ok_reg ? t_data_reg : '0;
    assign a_addr   = cmd.walk_run ? key_row(s1_entry.k1) : key_row(ev_code);

    always_ff @(posedge clk)
    begin
        s2_entry_reg <= s1_entry;
    end

    assign down1 = key_in_range(s2_entry_reg.k1) &&
                   km_a_reg[s2_entry_reg.k1[KROW_SHIFT-1:0]];
    assign down2 = key_in_range(s2_entry_reg.k2) &&
                   km_b_reg[s2_entry_reg.k2[KROW_SHIFT-1:0]];

    assign single_key = (s2_entry_reg.k1 != '0) && (s2_entry_reg.k2 == '0);
    assign pair_key   = (s2_entry_reg.k1 != '0) && (s2_entry_reg.k2 != '0);
    assign add_masks  = s2_valid_reg && ((single_key && down1) || (pair_key && down1 && down2));
    assign end_hit    = s2_valid_reg &&
                        ((s2_entry_reg.k1 == '0 && s2_entry_reg.k2 == '0) ||
                         (pair_key && down1 && down2));
    assign walk_done  = end_hit ||
                        (32'(idx_reg) == TABLE_ENTRIES && !s1_valid_reg && !s2_valid_reg);

    // Key-down map, one row of eight codes per word.
    always_comb
    begin
        key_row_upd = km_a_reg;
        key_row_upd[ev_code[KROW_SHIFT-1:0]] = (kind_reg == KIND_PRESS);
    end

    always_comb
    begin
        km_we    = 1'b0;
        km_waddr = clr_reg;
        km_wdata = '0;
        if (cmd.clear_run)
        begin
            km_we = 1'b1;
        end
        else if (cmd.key_write && key_in_range(ev_code))
        begin
            km_we    = 1'b1;
            km_waddr = key_row(ev_code);
            km_wdata = key_row_upd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (km_we)
        begin
            key_mem[km_waddr] <= km_wdata;
        end
        km_a_reg <= key_mem[a_addr];
        km_b_reg <= key_mem[key_row(s1_entry.k2)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_run)
        begin
            clr_reg <= status.clear_last ? '0 : clr_reg + 1'b1;
        end
    end

    // Column row masks.
    always_comb
    begin
        for (int c = 0; c < COLUMNS; c++)
        begin
            col_rows_next[c] = col_rows_reg[c];
            if (add_masks && s2_entry_reg.c1 == COL_W'(c))
            begin
                col_rows_next[c] = col_rows_next[c] | s2_entry_reg.m1;
            end
            if (add_masks && s2_entry_reg.c2 == COL_W'(c))
            begin
                col_rows_next[c] = col_rows_next[c] | s2_entry_reg.m2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                col_rows_reg[c] <= '0;
            end
        end
        else if (cmd.walk_start)
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                col_rows_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < COLUMNS; c++)
            begin
                col_rows_reg[c] <= col_rows_next[c];
            end
        end
    end

    // Column read: strobe bits are active low.
    always_comb
    begin
        sel = ~item_reg.column_select;
        acc = '0;
        for (int c = 0; c < COLUMNS; c++)
        begin
            if (sel[c])
            begin
                acc = acc | col_rows_reg[c];
            end
        end
        rd_val = READ_BASE - acc;
        if (item_reg.pot_value != '0 && item_reg.pot_value >= item_reg.dac_level)
        begin
            rd_val = rd_val | POT_BIT;
        end
        if (item_reg.buttons[1])
        begin
            rd_val = rd_val & LFIRE1_CLR;
        end
        if (item_reg.buttons[0])
        begin
            rd_val = rd_val & RFIRE1_CLR;
        end
        if (item_reg.buttons[3])
        begin
            rd_val = rd_val & LFIRE2_CLR;
        end
        if (item_reg.buttons[2])
        begin
            rd_val = rd_val & RFIRE2_CLR;
        end
    end

    assign read_data    = (kind_reg == KIND_READ) ? rd_val : '0;
    assign keyboard_irq = (kind_reg == KIND_PRESS) && irq_en_reg;

    assign status.kind          = kind_reg;
    assign status.shift_release = (kind_reg == KIND_RELEASE) && (ev_code == shift_reg);
    assign status.clear_last    = (clr_reg == KROW_AW'(KROWS - 1));
    assign status.walk_done     = walk_done;

endmodule

FILE: hdl/keyboard_matrix_translator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_translator_top
// Host key events to keyboard matrix rows, with column read and config port.
// ----------------------------------------------------------------------------
// One transaction is handled at a time and each produces exactly one result.
// A table load or column read passes through the dispatch and result states
// to the output register. A press or release runs the table walk, which reads
// one entry per cycle through the single read port of the table memory; it
// stops early at the terminator or at a matching two-key entry. Releasing
// shift first clears the key-down map, one 8-code row per cycle, in place of
// the single-row update. A clearing pass runs after reset, during which no
// transaction is accepted; configuration writes are taken at any time. A new
// transaction is accepted while the previous result still waits in the
// output register.
`include "keyboard_matrix_translator_top_macros.svh"

module keyboard_matrix_translator_top
    import kmt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index, scan_first, scan_second, row_first, col_first, row_second,
    // col_second, column_select, pot_value, dac_level, buttons, from bit 0 up
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [KIND_W-1:0]     s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // read_data, keyboard_irq, from bit 0 up
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    in_item_t   in_item;
    kind_t      in_kind;
    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       out_free;
    logic [MASK_W-1:0] read_data;
    logic              keyboard_irq;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign in_item = s_axis_tdata[$bits(in_item_t)-1:0];
    assign in_kind = kind_t'(s_axis_tuser);

    kmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    kmt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_kind      (in_kind),
        .in_item      (in_item),
        .cmd          (cmd),
        .status       (status),
        .read_data    (read_data),
        .keyboard_irq (keyboard_irq)
    );

    // Output register between the sequencer and the downstream consumer.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            out_data_reg <= OUT_DATA_W'({keyboard_irq, read_data});
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: dv/keyboard_matrix_translator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_matrix_translator_top_tb
// The testbench drives table loads, key events and column reads into the
// translator. A scoreboard keeps its own model of the key map, the
// translation table and the column rows, and checks each result against it.
// Stimulus starts with a directed sequence. Random episodes follow, each
// loading a table (mostly small) and then pressing and releasing keys
// from the same key pool, with column reads mixed in. The run goes through
// three register settings and three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------

class kmt_scoreboard;
    logic                  key_state [kmt_pkg::SCAN_CODES];
    kmt_pkg::tbl_entry_t   xlat_tbl [kmt_pkg::TABLE_ENTRIES];
    logic [7:0]            col_rows [kmt_pkg::COLUMNS];
    logic [8:0]            shift_code;
    logic [8:0]            rshift_code;
    logic                  irq_en;
    logic [15:0]           expected_q [$];
    int                    errors;
    int                    checked;
    int                    irq_seen;
    int                    kind_cnt [4];

    function new();
        shift_code  = kmt_pkg::SHIFT_RESET;
        rshift_code = kmt_pkg::RSHIFT_RESET;
        irq_en      = 1'b0;
        foreach (key_state[i]) key_state[i] = 1'b0;
        foreach (xlat_tbl[i]) xlat_tbl[i] = '0;
        foreach (col_rows[i]) col_rows[i] = '0;
        foreach (kind_cnt[i]) kind_cnt[i] = 0;
        errors   = 0;
        checked  = 0;
        irq_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] data);
        case (idx)
            kmt_pkg::CFG_SHIFT:  shift_code  = data;
            kmt_pkg::CFG_RSHIFT: rshift_code = data;
            kmt_pkg::CFG_IRQ_EN: irq_en      = data[0];
            default: ;
        endcase
    endfunction

    function bit is_down(logic [8:0] code);
        if (int'(code) >= kmt_pkg::SCAN_CODES)
            return 1'b0;
        return key_state[code] == 1'b1;
    endfunction

    function void rebuild_rows();
        kmt_pkg::tbl_entry_t ent;
        foreach (col_rows[i]) col_rows[i] = '0;
        for (int i = 0; i < kmt_pkg::TABLE_ENTRIES; i++)
        begin
            ent = xlat_tbl[i];
            if (ent.k1 == 0 && ent.k2 == 0)
                break;
            if (ent.k1 == 0)
                continue;
            if (ent.k2 == 0)
            begin
                if (is_down(ent.k1))
                begin
                    col_rows[ent.c1] |= ent.m1;
                    col_rows[ent.c2] |= ent.m2;
                end
            end
            else if (is_down(ent.k1) && is_down(ent.k2))
            begin
                // A matching two-key entry wins and stops the walk.
                col_rows[ent.c1] |= ent.m1;
                col_rows[ent.c2] |= ent.m2;
                break;
            end
        end
    endfunction

    function void note_input(kmt_pkg::kind_t kind, kmt_pkg::in_item_t it);
        kmt_pkg::tbl_entry_t ent;
        logic [8:0]          code;
        logic [7:0]          rd;
        logic [7:0]          acc;
        logic [7:0]          sel;
        logic                irq;
        rd  = '0;
        irq = 1'b0;
        kind_cnt[kind]++;
        case (kind)
            kmt_pkg::KIND_LOAD:
            begin
                ent.k1 = it.scan_first;
                ent.k2 = it.scan_second;
                ent.m1 = it.row_first;
                ent.c1 = it.col_first;
                ent.m2 = it.row_second;
                ent.c2 = it.col_second;
                if (ent.k2 == shift_code)
                begin
                    ent.k2 = ent.k1;
                    ent.k1 = shift_code;
                end
                if (ent.k1 == 0 && ent.k2 != 0)
                begin
                    ent.k1 = ent.k2;
                    ent.k2 = '0;
                end
                if (int'(it.entry_index) < kmt_pkg::TABLE_ENTRIES)
                    xlat_tbl[it.entry_index] = ent;
            end
            kmt_pkg::KIND_PRESS, kmt_pkg::KIND_RELEASE:
            begin
                code = it.scan_first;
                if (code == rshift_code)
                    code = shift_code;
                if (int'(code) < kmt_pkg::SCAN_CODES)
                    key_state[code] = (kind == kmt_pkg::KIND_PRESS);
                if (kind == kmt_pkg::KIND_RELEASE && code == shift_code)
                    foreach (key_state[i]) key_state[i] = 1'b0;
                rebuild_rows();
                irq = (kind == kmt_pkg::KIND_PRESS) && irq_en;
            end
            default:
            begin
                sel = ~it.column_select;
                acc = '0;
                for (int c = 0; c < 8; c++)
                    if (sel[c])
                        acc |= col_rows[c];
                rd = kmt_pkg::READ_BASE - acc;
                if (it.pot_value != 0 && it.pot_value >= it.dac_level)
                    rd |= kmt_pkg::POT_BIT;
                if (it.buttons[1]) rd &= kmt_pkg::LFIRE1_CLR;
                if (it.buttons[0]) rd &= kmt_pkg::RFIRE1_CLR;
                if (it.buttons[3]) rd &= kmt_pkg::LFIRE2_CLR;
                if (it.buttons[2]) rd &= kmt_pkg::RFIRE2_CLR;
            end
        endcase
        expected_q.push_back({7'b0, irq, rd});
    endfunction

    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (expected_q.size() == 0)
        begin
            $error("result 0x%04h arrived with no transaction pending", got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got[8] === 1'b1)
            irq_seen++;
        if (got[7:0] !== want[7:0])
        begin
            $error("read_data: expected 0x%02h, got 0x%02h", want[7:0], got[7:0]);
            errors++;
        end
        if (got[8] !== want[8])
        begin
            $error("keyboard_irq: expected %0b, got %0b", want[8], got[8]);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module keyboard_matrix_translator_top_tb;
    import kmt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int ITEM_W         = $bits(in_item_t);
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 2 * (TABLE_ENTRIES + 7 + SCAN_CODES / 8);
    localparam int PHASE_ITEMS    = 440;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kmt_scoreboard sb;
    int            src_idle_pct;
    int            snk_idle_pct;
    bit            hold_req;
    int            stall_cycles;
    logic [CODE_W-1:0] key_pool [8];

    keyboard_matrix_translator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_LOAD;
        m_axis_tready = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SHIFT;
        cfg_data      = '0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        hold_req      = 1'b0;
        stall_cycles  = 0;
    end

    always #5 clk = ~clk;

    // Receiver: random back-pressure, plus a long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Monitor: both handshakes are sampled at the edge where they complete.
    always @(posedge clk)
    begin
        if (rst_n && sb != null)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(kind_t'(s_axis_tuser), in_item_t'(s_axis_tdata[ITEM_W-1:0]));
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        while (stall_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic in_item_t random_item();
        in_item_t it;
        it.entry_index   = IDX_W'($urandom);
        it.scan_first    = CODE_W'($urandom);
        it.scan_second   = CODE_W'($urandom);
        it.row_first     = MASK_W'($urandom);
        it.col_first     = COL_W'($urandom);
        it.row_second    = MASK_W'($urandom);
        it.col_second    = COL_W'($urandom);
        it.column_select = SEL_W'($urandom);
        it.pot_value     = POT_W'($urandom);
        it.dac_level     = POT_W'($urandom);
        it.buttons       = BTN_W'($urandom);
        return it;
    endfunction

    function automatic logic [CODE_W-1:0] pick_key();
        return key_pool[$urandom_range(0, 7)];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic push_item(input kind_t kind, input in_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - ITEM_W){1'b0}}, it};
        s_axis_tuser  <= kind;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic push_load(input int slot, input logic [CODE_W-1:0] k1,
                             input logic [CODE_W-1:0] k2);
        in_item_t it;
        it             = random_item();
        it.entry_index = slot[IDX_W-1:0];
        it.scan_first  = k1;
        it.scan_second = k2;
        push_item(KIND_LOAD, it);
    endtask

    task automatic push_key(input kind_t kind, input logic [CODE_W-1:0] code);
        in_item_t it;
        it            = random_item();
        it.scan_first = code;
        push_item(kind, it);
    endtask

    task automatic push_read(input logic [7:0] sel, input logic [5:0] pot,
                             input logic [5:0] dac, input logic [3:0] btn);
        in_item_t it;
        it               = random_item();
        it.column_select = sel;
        it.pot_value     = pot;
        it.dac_level     = dac;
        it.buttons       = btn;
        push_item(KIND_READ, it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        in_item_t it;
        push_read(8'h00, 6'd0, 6'd0, 4'h0);
        // Shift as second code gets swapped to first.
        push_load(0, 9'd100, SHIFT_RESET);
        // A lone second code moves to first.
        push_load(1, 9'd0, 9'd200);
        push_load(2, 9'd150, 9'd0);
        push_load(3, 9'd150, 9'd200);
        push_load(4, 9'd511, 9'd0);
        push_load(5, 9'd0, 9'd0);
        // Beyond the terminator, never reached by the walk.
        it             = random_item();
        it.entry_index = 7'd6;
        it.scan_first  = 9'd50;
        it.scan_second = 9'd0;
        it.row_first   = 8'hFF;
        it.row_second  = 8'hFF;
        push_item(KIND_LOAD, it);
        push_key(KIND_PRESS, 9'd150);
        push_read(8'hFB, 6'd63, 6'd63, 4'h0);
        push_key(KIND_PRESS, 9'd200);
        push_read(8'h00, 6'd1, 6'd2, 4'hF);
        push_key(KIND_PRESS, RSHIFT_RESET);
        push_key(KIND_PRESS, 9'd100);
        push_read(8'h7E, 6'd0, 6'd0, 4'h1);
        push_key(KIND_RELEASE, 9'd100);
        push_key(KIND_PRESS, 9'd511);
        push_read(8'hFF, 6'd5, 6'd5, 4'h2);
        // Releasing shift drops every key.
        push_key(KIND_RELEASE, SHIFT_RESET);
        push_read(8'h00, 6'd0, 6'd63, 4'h4);
        push_key(KIND_PRESS, 9'd0);
        push_key(KIND_RELEASE, 9'd511);
        push_read(8'hBF, 6'd63, 6'd0, 4'h8);
        push_load(127, 9'd511, 9'd511);
    endtask

    // Table loads for one table, followed by a burst of key events and reads.
    task automatic run_episode(input bit full_tbl, inout int sent);
        int               n;
        int               m;
        int               roll;
        logic [CODE_W-1:0] a;
        logic [CODE_W-1:0] b;
        in_item_t         it;
        key_pool[0] = sb.shift_code;
        key_pool[1] = sb.rshift_code;
        for (int i = 2; i < 8; i++)
            key_pool[i] = CODE_W'($urandom_range(1, SCAN_CODES - 1));
        n = full_tbl ? TABLE_ENTRIES : $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            a    = pick_key();
            b    = pick_key();
            if (roll < 30)
                push_load(i, a, b);
            else if (roll < 40)
                push_load(i, a, sb.shift_code);
            else if (roll < 48)
                push_load(i, 9'd0, a);
            else if (roll < 53)
                push_load(i, CODE_W'($urandom), CODE_W'($urandom));
            else
                push_load(i, a, 9'd0);
            sent++;
        end
        if (n < TABLE_ENTRIES && $urandom_range(0, 9) != 0)
        begin
            push_load(n, 9'd0, 9'd0);
            sent++;
        end
        m = $urandom_range(8, 40);
        for (int j = 0; j < m; j++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 38)
                push_key(KIND_PRESS, pick_key());
            else if (roll < 68)
                push_key(KIND_RELEASE, pick_key());
            else if (roll < 93)
            begin
                it = random_item();
                if ($urandom_range(0, 3) != 0)
                    it.column_select = ~(8'h01 << $urandom_range(0, 7));
                if ($urandom_range(0, 2) == 0)
                    it.dac_level = POT_W'($urandom_range(0, it.pot_value));
                push_item(KIND_READ, it);
            end
            else
                push_item(kind_t'($urandom_range(0, 3)), random_item());
            sent++;
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct,
                             input logic [CODE_W-1:0] shift, input logic [CODE_W-1:0] rshift,
                             input logic irq_on, input bit pressure, input bit full_tbl);
        int sent;
        sent         = 0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_reg(CFG_SHIFT, shift);
        write_reg(CFG_RSHIFT, rshift);
        write_reg(CFG_IRQ_EN, {8'd0, irq_on});
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        if (full_tbl)
            run_episode(1'b1, sent);
        while (sent < PHASE_ITEMS)
        begin
            run_episode(1'b0, sent);
            // Hold the output off while the sender keeps going.
            if (pressure && sent < 60)
                hold_req = 1'b1;
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        drain();
        run_phase(19, 56, SHIFT_RESET, RSHIFT_RESET, 1'b1, 1'b1, 1'b0);
        run_phase(56, 19, 9'd511, 9'd0, 1'b0, 1'b0, 1'b0);
        run_phase(0, 0, 9'd0, 9'd511, 1'b1, 1'b0, 1'b1);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Covered %0d table loads, %0d presses, %0d releases, %0d column reads",
                 sb.kind_cnt[KIND_LOAD], sb.kind_cnt[KIND_PRESS],
                 sb.kind_cnt[KIND_RELEASE], sb.kind_cnt[KIND_READ]);
        $display("over three register settings; %0d results checked, %0d with interrupt.",
                 sb.checked, sb.irq_seen);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/kmt_pkg.sv
hdl/kmt_ctrl.sv
hdl/kmt_datapath.sv
hdl/keyboard_matrix_translator_top.sv
dv/keyboard_matrix_translator_top_tb.sv
